>>> rtl/nma_pkg.sv
// Shared types and constants of the nearest-medoid assignment unit.
// Used by every module of the block; depends on nothing.
package nma_pkg;

	localparam int MAX_CLUSTERS_DEF = 8;
	localparam int MAX_DIMS_DEF = 64;

	localparam int COORD_W = 16;
	localparam int MEDOID_IDX_W = 3;
	localparam int DIM_IDX_W = 6;
	localparam int ACC_W = 38;
	localparam int CLUSTERS_W = 4;
	localparam int CLUSTER_IDX_W = 3;

	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = ACC_W;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTERS_IN_USE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_LIMIT = 4'd1;

	localparam logic [CLUSTERS_W-1:0] CLUSTERS_RESET = 4'd8;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// One classified input item as it sits in the front queue.
	typedef struct packed {
		logic load;       // medoid coordinate write, indexes in range
		logic point;      // point coordinate
		logic dim_ok;     // dimension index inside the store
		logic ends_point; // point coordinate that carries the last mark
		logic [MEDOID_IDX_W-1:0] medoid_index;
		logic [DIM_IDX_W-1:0] dim_index;
		logic signed [COORD_W-1:0] coord_value;
	} item_t;

	typedef struct packed {
		logic found;
		logic [CLUSTER_IDX_W-1:0] cluster_index;
		logic [ACC_W-1:0] min_distance_sq;
	} result_t;

endpackage

>>> rtl/nearest_medoid_assign_unit.sv
// Nearest-medoid assignment unit. Mode-0 items (tuser = 0) load one
// coordinate of one medoid; mode-1 items (tuser = 1) stream the coordinates
// of a point, and the item with tlast gives one result: the lowest-indexed
// enabled medoid whose squared distance is smallest and below the limit.
// One coordinate is taken every clock cycle, set by the single read/write
// port of each medoid's coordinate memory and the one multiplier per medoid
// lane, unless the last coordinate of a point waits for a free output slot.
// A result passes the read, difference, square, accumulate and tree
// registers, then the output queue. Medoid entries read before they are
// written are undefined. Write the configuration only while the unit is idle.
// Depends on nma_pkg, nma_front, nma_back and nma_out.
module nearest_medoid_assign_unit #(
	parameter int MAX_CLUSTERS = nma_pkg::MAX_CLUSTERS_DEF,
	parameter int MAX_DIMS = nma_pkg::MAX_DIMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// medoid_index [2:0], dim_index [8:3], coord_value [24:9], zero [31:25]
	input  logic [nma_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// mode
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// cluster_index [2:0], min_distance_sq [40:3], zero [47:41]
	output logic [nma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// found
	output logic m_axis_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [nma_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [nma_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nma_pkg::*;

	localparam int OUT_DEPTH = $clog2(MAX_CLUSTERS) + 6;

	logic [CLUSTERS_W-1:0] clusters_q;
	logic [ACC_W-1:0] limit_q;
	logic q_valid, q_pop, room, res_valid;
	item_t q_item;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= CLUSTERS_RESET;
			limit_q <= ACC_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CLUSTERS_IN_USE: clusters_q <= cfg_data[CLUSTERS_W-1:0];
				CFG_DISTANCE_LIMIT: limit_q <= cfg_data[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	// An item that ends a point enters the back part only with a free output slot.
	assign q_pop = q_valid && (!q_item.ends_point || room);

	nma_front #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_DIMS(MAX_DIMS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	nma_back #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_DIMS(MAX_DIMS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.issue(q_pop),
		.item(q_item),
		.clusters_in_use(clusters_q),
		.distance_limit(limit_q),
		.res_valid(res_valid),
		.res(res)
	);

	nma_out #(
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.claim(q_pop && q_item.ends_point),
		.room(room),
		.res_valid(res_valid),
		.res(res),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

endmodule

>>> rtl/nma_front.sv
// Front part: accepts input items, classifies them and holds them in a
// two-entry queue for the back part. Depends on nma_pkg.
module nma_front #(
	parameter int MAX_CLUSTERS = nma_pkg::MAX_CLUSTERS_DEF,
	parameter int MAX_DIMS = nma_pkg::MAX_DIMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [nma_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	output logic q_valid,
	output nma_pkg::item_t q_item,
	input  logic q_pop
);
	import nma_pkg::*;

	item_t in_item;
	item_t queue_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	always_comb begin
		in_item.medoid_index = s_axis_tdata[MEDOID_IDX_W-1:0];
		in_item.dim_index = s_axis_tdata[MEDOID_IDX_W +: DIM_IDX_W];
		in_item.coord_value = s_axis_tdata[MEDOID_IDX_W + DIM_IDX_W +: COORD_W];
		in_item.dim_ok = int'(in_item.dim_index) < MAX_DIMS;
		in_item.point = s_axis_tuser;
		in_item.load = !s_axis_tuser && in_item.dim_ok
			&& (int'(in_item.medoid_index) < MAX_CLUSTERS);
		in_item.ends_point = s_axis_tuser && s_axis_tlast;
	end

	assign s_axis_tready = (count_q != 2'd2);
	assign push = s_axis_tvalid && s_axis_tready;
	assign q_valid = (count_q != 2'd0);
	assign q_item = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

>>> rtl/nma_back.sv
// Back part: per-medoid coordinate memories, difference, square and
// saturating accumulate lanes, and a registered minimum tree over the lanes.
// Depends on nma_pkg.
module nma_back #(
	parameter int MAX_CLUSTERS = nma_pkg::MAX_CLUSTERS_DEF,
	parameter int MAX_DIMS = nma_pkg::MAX_DIMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic issue,
	input  nma_pkg::item_t item,
	input  logic [nma_pkg::CLUSTERS_W-1:0] clusters_in_use,
	input  logic [nma_pkg::ACC_W-1:0] distance_limit,
	output logic res_valid,
	output nma_pkg::result_t res
);
	import nma_pkg::*;

	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CW = $clog2(MAX_CLUSTERS);
	localparam int LEAVES = 2 ** CW;

	logic [DW-1:0] addr;

	logic pv_s1, pv_s2, pv_s3;
	logic end_s1, end_s2, end_s3;
	logic dok_s1, dok_s2, dok_s3;
	logic signed [COORD_W-1:0] cv_s1;
	logic signed [COORD_W-1:0] rd_s1 [MAX_CLUSTERS];
	logic [COORD_W-1:0] ad_s2 [MAX_CLUSTERS];
	logic [2*COORD_W-1:0] sq_s3 [MAX_CLUSTERS];
	logic [ACC_W-1:0] acc_q [MAX_CLUSTERS];

	logic leaf_v_s4 [LEAVES];
	logic [ACC_W-1:0] leaf_d_s4 [LEAVES];
	logic node_v_q [1:LEAVES-1];
	logic [CW-1:0] node_i_q [1:LEAVES-1];
	logic [ACC_W-1:0] node_d_q [1:LEAVES-1];
	// Bit 0 marks the leaf stage; bit CW lines up with the root of the tree.
	logic [CW:0] tree_vld_q;

	assign addr = DW'(item.dim_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
			pv_s3 <= 1'b0;
			tree_vld_q <= '0;
		end else begin
			pv_s1 <= issue && item.point;
			pv_s2 <= pv_s1;
			pv_s3 <= pv_s2;
			tree_vld_q <= {tree_vld_q[CW-1:0], pv_s3 && end_s3};
		end
	end

	always_ff @(posedge clk) begin
		end_s1 <= item.ends_point;
		dok_s1 <= item.dim_ok;
		cv_s1 <= item.coord_value;
		end_s2 <= end_s1;
		dok_s2 <= dok_s1;
		end_s3 <= end_s2;
		dok_s3 <= dok_s2;
	end

	for (genvar j = 0; j < MAX_CLUSTERS; j++) begin : g_lane
		logic signed [COORD_W-1:0] mem [MAX_DIMS];
		logic signed [COORD_W:0] diff;
		logic [COORD_W:0] mag;
		logic [ACC_W:0] sum;
		logic [ACC_W-1:0] sum_sat;

		always_ff @(posedge clk) begin
			if (issue && item.load && (int'(item.medoid_index) == j)) begin
				mem[addr] <= item.coord_value;
			end
			rd_s1[j] <= mem[addr];
		end

		always_comb begin
			diff = (COORD_W+1)'(cv_s1) - (COORD_W+1)'(rd_s1[j]);
			mag = diff[COORD_W] ? -diff : diff;
			sum = (ACC_W+1)'(acc_q[j]) + (dok_s3 ? (ACC_W+1)'(sq_s3[j]) : '0);
			sum_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
		end

		always_ff @(posedge clk) begin
			ad_s2[j] <= mag[COORD_W-1:0];
			sq_s3[j] <= (2*COORD_W)'(ad_s2[j]) * (2*COORD_W)'(ad_s2[j]);
			leaf_d_s4[j] <= sum_sat;
			leaf_v_s4[j] <= (int'(clusters_in_use) > j) && (sum_sat < distance_limit);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[j] <= '0;
			end else if (pv_s3) begin
				acc_q[j] <= end_s3 ? '0 : sum_sat;
			end
		end
	end

	for (genvar j = MAX_CLUSTERS; j < LEAVES; j++) begin : g_pad
		assign leaf_v_s4[j] = 1'b0;
		assign leaf_d_s4[j] = '0;
	end

	// Node k merges nodes 2k and 2k+1; indexes from LEAVES up are the leaves.
	// The left child holds lower medoid indexes, so it wins a tie.
	for (genvar k = 1; k < LEAVES; k++) begin : g_node
		logic lv, rv, take_left;
		logic [CW-1:0] li, ri;
		logic [ACC_W-1:0] ld, rd;

		if (2 * k >= LEAVES) begin : g_from_leaf
			assign lv = leaf_v_s4[2*k - LEAVES];
			assign ld = leaf_d_s4[2*k - LEAVES];
			assign li = CW'(2*k - LEAVES);
			assign rv = leaf_v_s4[2*k + 1 - LEAVES];
			assign rd = leaf_d_s4[2*k + 1 - LEAVES];
			assign ri = CW'(2*k + 1 - LEAVES);
		end else begin : g_from_node
			assign lv = node_v_q[2*k];
			assign ld = node_d_q[2*k];
			assign li = node_i_q[2*k];
			assign rv = node_v_q[2*k + 1];
			assign rd = node_d_q[2*k + 1];
			assign ri = node_i_q[2*k + 1];
		end

		assign take_left = lv && (!rv || (ld <= rd));

		always_ff @(posedge clk) begin
			node_v_q[k] <= lv || rv;
			node_i_q[k] <= take_left ? li : ri;
			node_d_q[k] <= take_left ? ld : rd;
		end
	end

	assign res_valid = tree_vld_q[CW];

	always_comb begin
		res.found = node_v_q[1];
		res.cluster_index = node_v_q[1] ? CLUSTER_IDX_W'(node_i_q[1]) : '0;
		res.min_distance_sq = node_v_q[1] ? node_d_q[1] : '0;
	end

endmodule

>>> rtl/nma_out.sv
// Output queue of results and the count of results promised to it, which
// tells the issue logic whether a result-bearing item may enter the back
// part. Depends on nma_pkg.
module nma_out #(
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic claim,
	output logic room,
	input  logic res_valid,
	input  nma_pkg::result_t res,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [nma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic m_axis_tuser
);
	import nma_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);

	result_t buf_q [DEPTH];
	result_t head;
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OW-1:0] count_q, owed_q;
	logic pop;

	assign head = buf_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata = OUT_TDATA_W'({head.min_distance_sq, head.cluster_index});
	assign m_axis_tuser = head.found;
	assign pop = m_axis_tvalid && m_axis_tready;
	// Every result in flight or queued holds a slot, so the queue never overflows.
	assign room = owed_q < OW'(DEPTH);

	always_ff @(posedge clk) begin
		if (res_valid) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			owed_q <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OW'(res_valid) - OW'(pop);
			owed_q <= owed_q + OW'(claim) - OW'(pop);
		end
	end

endmodule

>>> dv/nearest_medoid_assign_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of nearest_medoid_assign_unit: a directed table, then random
// medoid loads and point streams under several register settings and backpressure patterns.
// Depends on nma_pkg and the unit RTL; results are checked by the table or the predictor.
module nearest_medoid_assign_unit_tb;

	import nma_pkg::*;

	localparam int NUM_MEDOIDS = MAX_CLUSTERS_DEF;
	localparam int NUM_DIMS = MAX_DIMS_DEF;
	localparam bit MODE_LOAD = 1'b0;
	localparam bit MODE_POINT = 1'b1;
	localparam longint SUM_CEIL = longint'(ACC_MAX);
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_ITEMS = 190;

	localparam bit [CLUSTERS_W-1:0] PHASE_CLUSTERS [8] = '{4'd8, 4'd1, 4'd0, 4'd15,
		4'd5, 4'd9, 4'd4, 4'd3};
	localparam logic [ACC_W-1:0] PHASE_LIMITS [8] = '{ACC_MAX, 38'd1 << 33, ACC_MAX,
		38'd1 << 34, 38'd0, ACC_MAX, 38'd1, 38'd1 << 32};

	typedef struct {
		bit mode;
		bit [MEDOID_IDX_W-1:0] medoid;
		bit [DIM_IDX_W-1:0] dim;
		logic signed [COORD_W-1:0] coord;
		bit last;
	} coord_item_t;

	typedef struct {
		bit mode;
		bit [MEDOID_IDX_W-1:0] medoid;
		bit [DIM_IDX_W-1:0] dim;
		int coord;
		bit last;
		bit typed;
		bit [CLUSTER_IDX_W-1:0] exp_index;
		longint exp_dist;
		bit exp_found;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state.
	logic signed [COORD_W-1:0] medoid_coords [NUM_MEDOIDS][NUM_DIMS];
	bit coord_written [NUM_MEDOIDS][NUM_DIMS];
	bit [NUM_DIMS-1:0] dim_ready;
	bit [DIM_IDX_W-1:0] ready_dims [$];
	logic [ACC_W-1:0] dist_sums [NUM_MEDOIDS];
	logic [CLUSTERS_W-1:0] cluster_count;
	logic [ACC_W-1:0] dist_limit;
	result_t expected_assignments [$];

	int fail_count;
	int items_sent;
	int src_idle_pct;
	int dst_idle_pct;
	bit hold_req;
	int hold_left;

	// Medoids at dim 0 are chosen so that most points below hit one of them exactly.
	stim_row_t directed_rows [17] = '{
		'{MODE_LOAD, 3'd0, 6'd0, 0, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_LOAD, 3'd1, 6'd0, 32767, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_LOAD, 3'd2, 6'd0, -32768, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_LOAD, 3'd3, 6'd0, 100, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_LOAD, 3'd4, 6'd0, -1, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_LOAD, 3'd5, 6'd0, 100, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_LOAD, 3'd6, 6'd0, 21845, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_LOAD, 3'd7, 6'd0, -21846, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		// A last mark on a load gives no result.
		'{MODE_LOAD, 3'd0, 6'd0, 0, 1'b1, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_POINT, 3'd0, 6'd0, 0, 1'b1, 1'b1, 3'd0, 0, 1'b1},
		'{MODE_POINT, 3'd5, 6'd0, 32767, 1'b1, 1'b1, 3'd1, 0, 1'b1},
		'{MODE_POINT, 3'd7, 6'd0, -32768, 1'b1, 1'b1, 3'd2, 0, 1'b1},
		// Medoids 3 and 5 tie; the lower index wins.
		'{MODE_POINT, 3'd0, 6'd0, 100, 1'b1, 1'b1, 3'd3, 0, 1'b1},
		'{MODE_POINT, 3'd0, 6'd0, 50, 1'b0, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_POINT, 3'd0, 6'd0, 150, 1'b1, 1'b0, 3'd0, 0, 1'b0},
		'{MODE_POINT, 3'd0, 6'd0, 21845, 1'b1, 1'b1, 3'd6, 0, 1'b1},
		'{MODE_POINT, 3'd0, 6'd0, -21846, 1'b1, 1'b1, 3'd7, 0, 1'b1}
	};

	nearest_medoid_assign_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("nearest_medoid_assign_unit_tb: FAIL");
		$finish;
	end

	function automatic coord_item_t make_item(bit mode, bit [MEDOID_IDX_W-1:0] medoid,
		bit [DIM_IDX_W-1:0] dim, logic signed [COORD_W-1:0] coord, bit last);
		coord_item_t it;
		it.mode = mode;
		it.medoid = medoid;
		it.dim = dim;
		it.coord = coord;
		it.last = last;
		return it;
	endfunction

	// Updates the medoid store or the running sums; on the last coordinate of a point
	// it picks the nearest enabled medoid and, if push is set, queues the assignment.
	function automatic void predict_assignment(coord_item_t it, bit push);
		int d;
		int n;
		longint sum;
		longint best;
		bit hit;
		bit full;
		bit [CLUSTER_IDX_W-1:0] idx;
		result_t res;
		if (it.mode == MODE_LOAD) begin
			medoid_coords[it.medoid][it.dim] = it.coord;
			coord_written[it.medoid][it.dim] = 1'b1;
			full = 1'b1;
			for (int j = 0; j < NUM_MEDOIDS; j++)
				full &= coord_written[j][it.dim];
			if (full && !dim_ready[it.dim]) begin
				dim_ready[it.dim] = 1'b1;
				ready_dims.push_back(it.dim);
			end
			return;
		end
		for (int j = 0; j < NUM_MEDOIDS; j++) begin
			d = int'(it.coord) - int'(medoid_coords[j][it.dim]);
			sum = longint'(dist_sums[j]) + longint'(d) * longint'(d);
			dist_sums[j] = (sum > SUM_CEIL) ? ACC_MAX : sum[ACC_W-1:0];
		end
		if (!it.last)
			return;
		n = (cluster_count > NUM_MEDOIDS) ? NUM_MEDOIDS : int'(cluster_count);
		best = longint'(dist_limit);
		hit = 1'b0;
		idx = '0;
		for (int j = 0; j < n; j++) begin
			if (longint'(dist_sums[j]) < best) begin
				best = longint'(dist_sums[j]);
				idx = CLUSTER_IDX_W'(j);
				hit = 1'b1;
			end
		end
		res.found = hit;
		res.cluster_index = hit ? idx : '0;
		res.min_distance_sq = hit ? best[ACC_W-1:0] : '0;
		if (push)
			expected_assignments.push_back(res);
		for (int j = 0; j < NUM_MEDOIDS; j++)
			dist_sums[j] = '0;
	endfunction

	task automatic send_coord(input coord_item_t it, input bit typed, input result_t typed_res);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, it.coord, it.dim, it.medoid};
		s_axis_tuser <= it.mode;
		s_axis_tlast <= it.last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_assignment(it, !typed);
		if (typed)
			expected_assignments.push_back(typed_res);
		items_sent++;
	endtask

	task automatic send_plain(input coord_item_t it);
		send_coord(it, 1'b0, '0);
	endtask

	task automatic set_config(input logic [CLUSTERS_W-1:0] clusters,
		input logic [ACC_W-1:0] limit);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CLUSTERS_IN_USE;
		cfg_data <= CFG_DATA_W'(clusters);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cluster_count = clusters;
		cfg_index <= CFG_DISTANCE_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		dist_limit = limit;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// A coordinate close to medoid t, so that small limits still see hits.
	function automatic logic signed [COORD_W-1:0] near_coord(int t, bit [DIM_IDX_W-1:0] d);
		int v;
		v = int'(medoid_coords[t][d]);
		if ($urandom_range(3) != 0)
			v = v + int'($urandom_range(128)) - 64;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return COORD_W'(v);
	endfunction

	function automatic bit [DIM_IDX_W-1:0] pick_ready_dim();
		return ready_dims[$urandom_range(ready_dims.size() - 1)];
	endfunction

	// Only dimensions written for every medoid are read by points.
	task automatic send_point(input int max_len);
		int len;
		int t;
		bit [DIM_IDX_W-1:0] d;
		len = $urandom_range(1, max_len);
		t = $urandom_range(NUM_MEDOIDS - 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(9) == 0) begin
				d = pick_ready_dim();
				send_plain(make_item(MODE_LOAD, MEDOID_IDX_W'($urandom), d, rand_coord(),
					1'($urandom)));
			end
			d = pick_ready_dim();
			send_plain(make_item(MODE_POINT, MEDOID_IDX_W'($urandom), d,
				($urandom_range(4) < 3) ? near_coord(t, d) : rand_coord(), k == len - 1));
		end
	endtask

	task automatic send_load_burst();
		bit [DIM_IDX_W-1:0] d;
		d = DIM_IDX_W'($urandom_range(NUM_DIMS - 1));
		for (int m = 0; m < NUM_MEDOIDS; m++)
			send_plain(make_item(MODE_LOAD, MEDOID_IDX_W'(m), d, rand_coord(),
				$urandom_range(15) == 0));
	endtask

	// Sixty-five or more coordinates at the full distance 65535 overflow 38 bits, so the
	// far medoids saturate; when all of them are far, nothing is found.
	task automatic send_saturating_point();
		bit [DIM_IDX_W-1:0] d;
		logic signed [COORD_W-1:0] near_val;
		logic signed [COORD_W-1:0] far_val;
		bit all_far;
		int len;
		d = DIM_IDX_W'($urandom_range(NUM_DIMS - 1));
		near_val = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		far_val = (near_val == 16'sh7fff) ? 16'sh8000 : 16'sh7fff;
		all_far = 1'($urandom_range(1));
		for (int m = 0; m < NUM_MEDOIDS; m++)
			send_plain(make_item(MODE_LOAD, MEDOID_IDX_W'(m), d,
				(all_far || $urandom_range(1)) ? far_val : near_val, 1'b0));
		len = $urandom_range(66, 72);
		for (int k = 0; k < len; k++)
			send_plain(make_item(MODE_POINT, '0, d, near_val, k == len - 1));
	endtask

	task automatic run_random(input int budget);
		int stop;
		int r;
		stop = items_sent + budget;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (ready_dims.size() == 0 || r < 12)
				send_load_burst();
			else if (r < 16)
				send_plain(make_item(MODE_LOAD, MEDOID_IDX_W'($urandom),
					DIM_IDX_W'($urandom), rand_coord(), 1'($urandom)));
			else if (r < 17)
				send_saturating_point();
			else
				send_point(8);
		end
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		while (expected_assignments.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Result receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_axis_tready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_assignments.size() == 0) begin
				$error("result with no point pending: tdata=%h found=%b",
					m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = expected_assignments.pop_front();
				if (m_axis_tdata[2:0] !== want.cluster_index) begin
					$error("cluster_index: expected %0d, got %0d", want.cluster_index,
						m_axis_tdata[2:0]);
					fail_count++;
				end
				if (m_axis_tdata[40:3] !== want.min_distance_sq) begin
					$error("min_distance_sq: expected %0d, got %0d", want.min_distance_sq,
						m_axis_tdata[40:3]);
					fail_count++;
				end
				if (m_axis_tuser !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	initial begin
		result_t typed_res;
		stim_row_t row;
		logic [ACC_W-1:0] limit;
		fail_count = 0;
		items_sent = 0;
		hold_req = 1'b0;
		dim_ready = '0;
		for (int j = 0; j < NUM_MEDOIDS; j++) begin
			dist_sums[j] = '0;
			for (int k = 0; k < NUM_DIMS; k++) begin
				medoid_coords[j][k] = '0;
				coord_written[j][k] = 1'b0;
			end
		end
		cluster_count = CLUSTERS_RESET;
		dist_limit = ACC_MAX;
		src_idle_pct = 29;
		dst_idle_pct = 74;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		s_axis_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			typed_res.found = row.exp_found;
			typed_res.cluster_index = row.exp_index;
			typed_res.min_distance_sq = row.exp_dist[ACC_W-1:0];
			send_coord(make_item(row.mode, row.medoid, row.dim, COORD_W'(row.coord), row.last),
				row.typed, typed_res);
		end

		for (int p = 0; p < 8; p++) begin
			// The sender stops until every assignment is back, then the pipeline drains.
			s_axis_tvalid <= 1'b0;
			wait_drained();
			repeat (16) @(posedge clk);
			limit = (p == 5) ? ACC_W'({$urandom, $urandom}) : PHASE_LIMITS[p];
			set_config(PHASE_CLUSTERS[p], limit);
			if (p < 3) begin
				src_idle_pct = 29;
				dst_idle_pct = 74;
			end else if (p < 6) begin
				src_idle_pct = 74;
				dst_idle_pct = 29;
			end else begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			if (p == 6) begin
				// Single-coordinate points pile up results while the output is held off.
				hold_req = 1'b1;
				repeat (60) send_point(1);
			end
			run_random(PHASE_ITEMS);
		end

		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_assignments.size() != 0) begin
			$error("%0d assignments never arrived", expected_assignments.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("nearest_medoid_assign_unit_tb: PASS");
		else
			$display("nearest_medoid_assign_unit_tb: FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/nma_pkg.sv
rtl/nma_front.sv
rtl/nma_back.sv
rtl/nma_out.sv
rtl/nearest_medoid_assign_unit.sv
dv/nearest_medoid_assign_unit_tb.sv
